// File: hdl/bpa_pkg.sv
// Package for the buddy page allocator: request and response words,
// operation and status codes, sequencer states and level table helpers.
// No dependencies.
package bpa_pkg;

  localparam int ADDR_W    = 48;
  localparam int LEN_W     = 25;
  localparam int ORDER_W   = 6;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int WORD_W    = 32;
  localparam int BIT_W     = 5;
  localparam int WADDR_W   = ADDR_W + 1;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_MIN_BLOCK_LOG2 = 12;
  localparam int DEF_MAX_BLOCK_LOG2 = 22;
  localparam int DEF_REGION_PAGES   = 4096;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INVAL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NOP   = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_MISS    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_TOO_BIG = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NULL    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_LENGTH = 1'd1;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ORDER_W-1:0] order_log2;
    logic [ADDR_W-1:0]  address;
  } bpa_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   block_address;
    logic [STATUS_W-1:0] status;
  } bpa_rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_FIND, S_SCAN_RD, S_SCAN_CHK, S_ALLOC_ADDR,
    S_ALLOC_SPLIT, S_MERGE, S_INV_SEARCH, S_INV_SPLIT, S_OFF, S_SLOT, S_RMW,
    S_POST, S_DONE
  } bpa_state_t;

  typedef enum logic [2:0] {
    PH_FREE_CHK, PH_MERGE, PH_FINAL, PH_SPLIT, PH_INV_SEARCH, PH_INV_SPLIT
  } bpa_phase_t;

  typedef enum logic [1:0] {
    OP_CHECK, OP_TAKE, OP_MARK
  } bpa_op_t;

  // first bitmap slot of a level: levels are packed one after another
  function automatic int bpa_level_start(int pages, int lvl);
    int s;
    s = 0;
    for (int i = 0; i < lvl; i++) begin
      s = s + (pages >> i);
    end
    return s;
  endfunction

endpackage

// File: hdl/bpa_map_ram.sv
// Free bitmap store, 32-bit rows, one write and one registered read port.
// No dependencies.
module bpa_map_ram #(
  parameter int ROWS   = 256,
  parameter int ROW_W  = 8,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ROW_W-1:0]  waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ROW_W-1:0]  raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/buddy_page_allocator_top.sv
// Buddy page allocator: sequencer, slot mapping unit and per-level counts.
// Depends on bpa_pkg and bpa_map_ram.
// Allocate probes levels, scans bitmap rows and then splits; free runs merge steps;
// invalidate probes levels and then splits. One word in flight; the bitmap
// read-modify-write port sets the pace. After reset a clearing pass runs first.
module buddy_page_allocator_top #(
  parameter int MIN_BLOCK_LOG2 = bpa_pkg::DEF_MIN_BLOCK_LOG2,
  parameter int MAX_BLOCK_LOG2 = bpa_pkg::DEF_MAX_BLOCK_LOG2,
  parameter int REGION_PAGES   = bpa_pkg::DEF_REGION_PAGES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  bpa_pkg::bpa_req_t               req,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output bpa_pkg::bpa_rsp_t               rsp,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpa_pkg::ADDR_W-1:0]      cfg_data
);
  import bpa_pkg::*;

  localparam int LEVELS   = MAX_BLOCK_LOG2 - MIN_BLOCK_LOG2 + 1;
  localparam int LW       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int MAP_BITS = 2 * REGION_PAGES;
  localparam int SW       = $clog2(MAP_BITS);
  localparam int ROWS     = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int RW       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW       = $clog2(REGION_PAGES + 1);

  bpa_state_t state, state_next;
  bpa_phase_t phase;
  bpa_op_t    op;

  logic [ADDR_W-1:0]   region_base;
  logic [LEN_W-1:0]    region_length;
  logic [WADDR_W-1:0]  region_end;
  bpa_req_t            req_r;
  logic [LW-1:0]       cur, tgt, op_lvl;
  logic [WADDR_W-1:0]  addr_r, op_addr, off_r;
  logic                borrow_r, op_ok;
  logic [SW-1:0]       slot_r, b_r;
  logic [RW-1:0]       scan_row, scan_last, clr_row;
  logic [STATUS_W-1:0] status_r;
  logic [ADDR_W-1:0]   result_r;
  logic [CW-1:0]       cnt [LEVELS];

  logic [SW-1:0] lvl_start  [LEVELS];
  logic [CW-1:0] lvl_blocks [LEVELS];

  for (genvar g = 0; g < LEVELS; g++) begin : g_lvl
    assign lvl_start[g]  = SW'(bpa_level_start(REGION_PAGES, g));
    assign lvl_blocks[g] = CW'(REGION_PAGES >> g);
  end

  logic              mem_we, mem_re;
  logic [RW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, map_rdata;

  bpa_map_ram #(.ROWS(ROWS), .ROW_W(RW), .DATA_W(WORD_W)) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (map_rdata)
  );

  logic [ORDER_W-1:0] ord_cur, ord_dn, ord_op;
  logic [WADDR_W-1:0] bit_cur, bit_dn, buddy, inv_base, upper, align_mask, blk;
  logic               cur_top, cur_zero, in_reg, page_lo, too_big;
  logic [LW-1:0]      lvl_req;
  logic               aligned, slot_ok;
  logic [SW-1:0]      slot_c, last_slot;
  logic [SW:0]        scan_lim, slot_i;
  logic [WORD_W-1:0]  hit_vec;
  logic [BIT_W-1:0]   sel;
  logic               hit, rd_bit;
  logic [SW-1:0]      hit_slot;

  assign ord_cur  = ORDER_W'(cur) + ORDER_W'(MIN_BLOCK_LOG2);
  assign ord_dn   = ord_cur - ORDER_W'(1);
  assign ord_op   = ORDER_W'(op_lvl) + ORDER_W'(MIN_BLOCK_LOG2);
  assign bit_cur  = WADDR_W'(1) << ord_cur;
  assign bit_dn   = WADDR_W'(1) << ord_dn;
  assign cur_top  = (cur == LW'(LEVELS - 1));
  assign cur_zero = (cur == '0);
  assign buddy    = addr_r ^ bit_cur;
  assign in_reg   = (buddy >= {1'b0, region_base}) && (buddy < region_end);
  assign inv_base = {1'b0, req_r.address} & ~(bit_cur - WADDR_W'(1));
  assign upper    = addr_r + bit_dn;
  assign page_lo  = {1'b0, req_r.address} < upper;
  assign too_big  = req_r.order_log2 > ORDER_W'(MAX_BLOCK_LOG2);
  assign lvl_req  = (req_r.order_log2 < ORDER_W'(MIN_BLOCK_LOG2)) ? '0 :
                    LW'(req_r.order_log2 - ORDER_W'(MIN_BLOCK_LOG2));

  // slot mapping unit
  assign align_mask = (WADDR_W'(1) << ord_op) - WADDR_W'(1);
  assign aligned    = (off_r & align_mask) == '0;
  assign blk        = off_r >> ord_op;
  assign slot_ok    = !borrow_r && aligned && (blk < WADDR_W'(lvl_blocks[op_lvl]));
  assign slot_c     = lvl_start[op_lvl] + SW'(blk);
  assign rd_bit     = map_rdata[slot_r[BIT_W-1:0]];

  // row scan
  assign scan_lim  = (SW+1)'(lvl_start[cur]) + (SW+1)'(lvl_blocks[cur]);
  assign last_slot = SW'(scan_lim - (SW+1)'(1));

  always_comb begin
    hit_vec = '0;
    sel     = '0;
    slot_i  = '0;
    for (int i = 0; i < WORD_W; i++) begin
      slot_i = ((SW+1)'(scan_row) << BIT_W) | (SW+1)'(i);
      hit_vec[i] = map_rdata[i] && (slot_i >= (SW+1)'(lvl_start[cur])) &&
                   (slot_i < scan_lim);
    end
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        sel = BIT_W'(i);
      end
    end
    hit = |hit_vec;
  end

  assign hit_slot = SW'(((SW+1)'(scan_row) << BIT_W) | (SW+1)'(sel));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:       if (clr_row == RW'(ROWS - 1)) state_next = S_IDLE;
      S_IDLE:        if (req_valid) state_next = S_DECODE;
      S_DECODE: begin
        unique case (req_r.kind)
          KIND_ALLOC: state_next = too_big ? S_DONE : S_FIND;
          KIND_FREE:  state_next = (req_r.address == '0 || too_big) ? S_DONE : S_OFF;
          KIND_INVAL: state_next = S_INV_SEARCH;
          default:    state_next = S_DONE;
        endcase
      end
      S_FIND: begin
        if (cnt[cur] != '0) state_next = S_SCAN_RD;
        else if (cur_top) state_next = S_DONE;
      end
      S_SCAN_RD:     state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (hit) state_next = S_ALLOC_ADDR;
        else if (scan_row == scan_last) state_next = S_DONE;
        else state_next = S_SCAN_RD;
      end
      S_ALLOC_ADDR:  state_next = S_ALLOC_SPLIT;
      S_ALLOC_SPLIT: state_next = (cur == tgt) ? S_DONE : S_OFF;
      S_MERGE:       state_next = S_OFF;
      S_INV_SEARCH:  state_next = S_OFF;
      S_INV_SPLIT:   state_next = cur_zero ? S_DONE : S_OFF;
      S_OFF:         state_next = S_SLOT;
      S_SLOT:        state_next = (!slot_ok || op == OP_CHECK) ? S_POST : S_RMW;
      S_RMW:         state_next = S_POST;
      S_POST: begin
        unique case (phase)
          PH_FREE_CHK:   state_next = op_ok ? S_MERGE : S_DONE;
          PH_MERGE:      state_next = op_ok ? S_MERGE : S_OFF;
          PH_FINAL:      state_next = S_DONE;
          PH_SPLIT:      state_next = S_ALLOC_SPLIT;
          PH_INV_SEARCH: state_next = op_ok ? S_INV_SPLIT :
                                      (cur_zero ? S_DONE : S_INV_SEARCH);
          default:       state_next = S_INV_SPLIT;
        endcase
      end
      default:       if (!rsp_valid || rsp_ready) state_next = S_IDLE;
    endcase
  end

  // outputs and memory control
  always_comb begin
    req_ready = (state == S_IDLE);
    cfg_ready = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_row;
      end
      S_SCAN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = scan_row;
      end
      S_SCAN_CHK: begin
        mem_we    = hit;
        mem_waddr = scan_row;
        mem_wdata = map_rdata & ~(WORD_W'(1) << sel);
      end
      S_SLOT: begin
        mem_re    = 1'b1;
        mem_raddr = RW'(slot_c >> BIT_W);
      end
      S_RMW: begin
        mem_waddr = RW'(slot_r >> BIT_W);
        if (op == OP_TAKE) begin
          mem_we    = rd_bit;
          mem_wdata = map_rdata & ~(WORD_W'(1) << slot_r[BIT_W-1:0]);
        end else begin
          mem_we    = !rd_bit;
          mem_wdata = map_rdata | (WORD_W'(1) << slot_r[BIT_W-1:0]);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_row       <= '0;
      rsp_valid     <= 1'b0;
      region_base   <= '0;
      region_length <= '0;
      for (int i = 0; i < LEVELS; i++) cnt[i] <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_row <= clr_row + RW'(1);
      if (cfg_valid) begin
        if (cfg_index == CFG_REGION_BASE) region_base <= cfg_data;
        if (cfg_index == CFG_REGION_LENGTH) region_length <= cfg_data[LEN_W-1:0];
      end
      if (state == S_DONE && (!rsp_valid || rsp_ready)) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      if (state == S_SCAN_CHK && hit) cnt[cur] <= cnt[cur] - CW'(1);
      if (state == S_RMW) begin
        if (op == OP_TAKE && rd_bit) cnt[op_lvl] <= cnt[op_lvl] - CW'(1);
        if (op == OP_MARK && !rd_bit) cnt[op_lvl] <= cnt[op_lvl] + CW'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    region_end <= {1'b0, region_base} + WADDR_W'(region_length);
    case (state)
      S_IDLE: if (req_valid) req_r <= req;
      S_DECODE: begin
        result_r <= '0;
        status_r <= STAT_DONE;
        case (req_r.kind)
          KIND_ALLOC: begin
            if (too_big) status_r <= STAT_TOO_BIG;
            cur <= lvl_req;
            tgt <= lvl_req;
          end
          KIND_FREE: begin
            if (req_r.address == '0) status_r <= STAT_NULL;
            else if (too_big) status_r <= STAT_TOO_BIG;
            addr_r  <= {1'b0, req_r.address};
            op_addr <= {1'b0, req_r.address};
            cur     <= lvl_req;
            op_lvl  <= lvl_req;
            op      <= OP_CHECK;
            phase   <= PH_FREE_CHK;
          end
          KIND_INVAL: cur <= LW'(LEVELS - 1);
          default: ;
        endcase
      end
      S_FIND: begin
        if (cnt[cur] == '0) begin
          if (cur_top) status_r <= STAT_MISS;
          else cur <= cur + LW'(1);
        end else begin
          scan_row  <= RW'(lvl_start[cur] >> BIT_W);
          scan_last <= RW'(last_slot >> BIT_W);
        end
      end
      S_SCAN_CHK: begin
        if (hit) b_r <= hit_slot - lvl_start[cur];
        else if (scan_row == scan_last) status_r <= STAT_MISS;
        else scan_row <= scan_row + RW'(1);
      end
      S_ALLOC_ADDR: addr_r <= {1'b0, region_base} + (WADDR_W'(b_r) << ord_cur);
      S_ALLOC_SPLIT: begin
        if (cur == tgt) begin
          result_r <= addr_r[ADDR_W-1:0];
        end else begin
          cur     <= cur - LW'(1);
          op_lvl  <= cur - LW'(1);
          op_addr <= upper;
          op      <= OP_MARK;
          phase   <= PH_SPLIT;
        end
      end
      S_MERGE: begin
        op_lvl <= cur;
        if (cur_top || !in_reg) begin
          op_addr <= addr_r;
          op      <= OP_MARK;
          phase   <= PH_FINAL;
        end else begin
          op_addr <= buddy;
          op      <= OP_TAKE;
          phase   <= PH_MERGE;
        end
      end
      S_INV_SEARCH: begin
        op_addr <= inv_base;
        op_lvl  <= cur;
        op      <= OP_TAKE;
        phase   <= PH_INV_SEARCH;
      end
      S_INV_SPLIT: begin
        if (!cur_zero) begin
          cur    <= cur - LW'(1);
          op_lvl <= cur - LW'(1);
          op     <= OP_MARK;
          phase  <= PH_INV_SPLIT;
          if (page_lo) begin
            op_addr <= upper;
          end else begin
            op_addr <= addr_r;
            addr_r  <= upper;
          end
        end
      end
      S_OFF: {borrow_r, off_r} <= {1'b0, op_addr} - {2'b00, region_base};
      S_SLOT: begin
        slot_r <= slot_c;
        op_ok  <= slot_ok;
      end
      S_RMW: op_ok <= (op == OP_TAKE) ? rd_bit : 1'b1;
      S_POST: begin
        case (phase)
          PH_FREE_CHK: if (!op_ok) status_r <= STAT_MISS;
          PH_MERGE: begin
            if (op_ok) begin
              addr_r <= addr_r & ~bit_cur;
              cur    <= cur + LW'(1);
            end else begin
              op_addr <= addr_r;
              op_lvl  <= cur;
              op      <= OP_MARK;
              phase   <= PH_FINAL;
            end
          end
          PH_INV_SEARCH: begin
            if (op_ok) addr_r <= op_addr;
            else if (cur_zero) status_r <= STAT_MISS;
            else cur <= cur - LW'(1);
          end
          default: ;
        endcase
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp.block_address <= result_r;
          rsp.status        <= status_r;
        end
      end
      default: ;
    endcase
  end

  a_rsp_zero_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != STAT_DONE |-> rsp.block_address == '0)
    else $error("nonzero address with failing status");

  a_scan_count: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN_CHK && hit |-> cnt[cur] != '0)
    else $error("free bit found at level with zero count");

  a_take_count: assert property (@(posedge clk) disable iff (rst)
    state == S_RMW && op == OP_TAKE && rd_bit |-> cnt[op_lvl] != '0)
    else $error("take from level with zero count");

  a_hold_done: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && rsp_valid && !rsp_ready |=> state == S_DONE)
    else $error("left done while response held");

  a_idle_out: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !req_ready && !rsp_valid)
    else $error("activity during clearing pass");

endmodule
